// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/i2cms_pkg.sv
// Types, codes and helpers of the I2C master transfer sequencer.
// No dependencies; used by every module of the block.
package i2cms_pkg;

	localparam int RES_MAX     = 5;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 24;

	// command codes
	localparam logic [2:0] CMD_START_WR   = 3'd0;
	localparam logic [2:0] CMD_START_RD   = 3'd1;
	localparam logic [2:0] CMD_START_SENT = 3'd2;
	localparam logic [2:0] CMD_ADDR_DONE  = 3'd3;
	localparam logic [2:0] CMD_BYTE_DONE  = 3'd4;
	localparam logic [2:0] CMD_TX_EMPTY   = 3'd5;
	localparam logic [2:0] CMD_RX_FULL    = 3'd6;
	localparam logic [2:0] CMD_ERROR      = 3'd7;

	// transfer states
	localparam logic [1:0] XS_READY = 2'd0;
	localparam logic [1:0] XS_TX    = 2'd1;
	localparam logic [1:0] XS_RX    = 2'd2;

	// notice codes; error notices start at NOTE_ERR_BASE in flag order
	localparam logic [3:0] NOTE_NONE     = 4'd0;
	localparam logic [3:0] NOTE_TX_DONE  = 4'd1;
	localparam logic [3:0] NOTE_RX_DONE  = 4'd2;
	localparam logic [3:0] NOTE_DATA_REQ = 4'd4;
	localparam logic [3:0] NOTE_DATA_RCV = 4'd5;
	localparam logic [3:0] NOTE_ERR_BASE = 4'd6;

	localparam logic [0:0] REG_ACK_ENABLE = 1'b0;

	typedef struct packed {
		logic [4:0]  error_flags;
		logic        tx_empty_too;
		logic        transmitter;
		logic        master_mode;
		logic [7:0]  data_byte;
		logic        repeated_start;
		logic [15:0] length;
		logic [6:0]  slave_address;
		logic [2:0]  command;
	} item_t;

	typedef struct packed {
		logic [1:0] prior_state;
		logic [3:0] notice;
		logic       ack_out;
		logic       generate_stop;
		logic       generate_start;
		logic       deliver_byte;
		logic       write_data_reg;
		logic [7:0] data_out;
	} res_t;

	typedef struct packed {
		logic [1:0]  xfer_state;
		logic [15:0] tx_rem;
		logic [15:0] rx_rem;
		logic [15:0] rx_total;
		logic [6:0]  tgt;
		logic        hold;
		logic        ack;
		logic        ev_on;
		logic        buf_on;
		logic        err_on;
	} state_t;

	function automatic res_t make_res(input logic [7:0] dout, input logic wr,
			input logic dlv, input logic st, input logic sp, input logic ack,
			input logic [3:0] note, input logic [1:0] prior);
		res_t r;
		r.data_out       = dout;
		r.write_data_reg = wr;
		r.deliver_byte   = dlv;
		r.generate_start = st;
		r.generate_stop  = sp;
		r.ack_out        = ack;
		r.notice         = note;
		r.prior_state    = prior;
		return r;
	endfunction

endpackage

// File: rtl/i2cms_step.sv
// Next-state and result-batch logic for one input word of the sequencer.
// Depends on i2cms_pkg.
module i2cms_step (
	input  i2cms_pkg::state_t                       cur,
	input  i2cms_pkg::item_t                        item,
	input  logic                                    ack_enable,
	output i2cms_pkg::state_t                       nxt,
	output i2cms_pkg::res_t [i2cms_pkg::RES_MAX-1:0] res,
	output logic [2:0]                              count
);
	import i2cms_pkg::*;

	always_comb begin : step_logic
		logic [2:0]  n;
		logic        a;
		logic [15:0] rem;
		logic        bufev;
		nxt   = cur;
		n     = 3'd0;
		a     = cur.ack;
		rem   = cur.rx_rem;
		bufev = cur.ev_on & cur.buf_on;
		for (int k = 0; k < RES_MAX; k++) begin
			res[k] = make_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, cur.ack, NOTE_NONE, XS_READY);
		end
		unique case (item.command)
			CMD_START_WR, CMD_START_RD: begin
				if (cur.xfer_state == XS_TX || cur.xfer_state == XS_RX) begin
					res[0] = make_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, a, NOTE_NONE,
						cur.xfer_state);
					n = 3'd1;
				end else begin
					if (item.command == CMD_START_WR) begin
						nxt.tx_rem     = item.length;
						nxt.xfer_state = XS_TX;
					end else begin
						nxt.rx_rem     = item.length;
						nxt.rx_total   = item.length;
						nxt.xfer_state = XS_RX;
					end
					nxt.tgt    = item.slave_address;
					nxt.hold   = item.repeated_start;
					nxt.ev_on  = 1'b1;
					nxt.buf_on = 1'b1;
					nxt.err_on = 1'b1;
					res[0] = make_res(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, a, NOTE_NONE,
						cur.xfer_state);
					n = 3'd1;
				end
			end
			CMD_START_SENT: begin
				// address byte with the R/W bit
				if (cur.ev_on && cur.xfer_state == XS_TX) begin
					res[0] = make_res({cur.tgt, 1'b0}, 1'b1, 1'b0, 1'b0, 1'b0, a,
						NOTE_NONE, XS_READY);
					n = 3'd1;
				end else if (cur.ev_on && cur.xfer_state == XS_RX) begin
					res[0] = make_res({cur.tgt, 1'b1}, 1'b1, 1'b0, 1'b0, 1'b0, a,
						NOTE_NONE, XS_READY);
					n = 3'd1;
				end
			end
			CMD_ADDR_DONE: begin
				if (cur.ev_on && item.master_mode && cur.xfer_state == XS_RX
						&& cur.rx_total == 16'd1) begin
					nxt.ack = 1'b0;
				end
			end
			CMD_BYTE_DONE: begin
				if (cur.ev_on && cur.xfer_state == XS_TX && item.tx_empty_too
						&& cur.tx_rem == 16'd0) begin
					nxt.ev_on      = 1'b0;
					nxt.buf_on     = 1'b0;
					nxt.xfer_state = XS_READY;
					nxt.tx_rem     = 16'd0;
					res[0] = make_res(8'h00, 1'b0, 1'b0, 1'b0, !cur.hold, a,
						NOTE_TX_DONE, XS_READY);
					n = 3'd1;
				end
			end
			CMD_TX_EMPTY: begin
				if (bufev) begin
					if (item.master_mode) begin
						if (cur.xfer_state == XS_TX && cur.tx_rem != 16'd0) begin
							nxt.tx_rem = cur.tx_rem - 16'd1;
							res[0] = make_res(item.data_byte, 1'b1, 1'b0, 1'b0, 1'b0, a,
								NOTE_NONE, XS_READY);
							n = 3'd1;
						end
					end else if (item.transmitter) begin
						res[0] = make_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, a,
							NOTE_DATA_REQ, XS_READY);
						n = 3'd1;
					end
				end
			end
			CMD_RX_FULL: begin
				if (bufev) begin
					if (item.master_mode) begin
						if (cur.xfer_state == XS_RX) begin
							if (cur.rx_total != 16'd0) begin
								// drop ack ahead of the final byte
								if (cur.rx_total > 16'd1 && rem == 16'd2) begin
									a = 1'b0;
								end
								rem    = rem - 16'd1;
								res[0] = make_res(item.data_byte, 1'b0, 1'b1, 1'b0, 1'b0,
									a, NOTE_NONE, XS_READY);
								n = 3'd1;
							end
							nxt.rx_rem = rem;
							if (rem == 16'd0) begin
								nxt.ev_on      = 1'b0;
								nxt.buf_on     = 1'b0;
								nxt.xfer_state = XS_READY;
								nxt.rx_rem     = 16'd0;
								nxt.rx_total   = 16'd0;
								if (ack_enable) begin
									a = 1'b1;
								end
								res[n] = make_res(8'h00, 1'b0, 1'b0, 1'b0, !cur.hold, a,
									NOTE_RX_DONE, XS_READY);
								n = n + 3'd1;
							end
							nxt.ack = a;
						end
					end else if (!item.transmitter) begin
						res[0] = make_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, a,
							NOTE_DATA_RCV, XS_READY);
						n = 3'd1;
					end
				end
			end
			CMD_ERROR: begin
				// one notice per set flag, lowest flag first
				if (cur.err_on) begin
					for (int k = 0; k < RES_MAX; k++) begin
						if (item.error_flags[k]) begin
							res[n] = make_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, a,
								4'(NOTE_ERR_BASE + 4'(k)), XS_READY);
							n = n + 3'd1;
						end
					end
				end
			end
		endcase
		// no effect: one null result carrying the acknowledge bit as it now stands
		if (n == 3'd0) begin
			res[0] = make_res(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, nxt.ack, NOTE_NONE, XS_READY);
			n = 3'd1;
		end
		count = n;
	end

endmodule

// File: rtl/i2cms_outq.sv
// Result bank of the sequencer: holds one word's batch and streams it out.
// Depends on i2cms_pkg.
module i2cms_outq (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    load,
	input  i2cms_pkg::res_t [i2cms_pkg::RES_MAX-1:0] bank,
	input  logic [2:0]                              count,
	output logic                                    free,
	output logic                                    tvalid,
	input  logic                                    tready,
	output logic [i2cms_pkg::OUT_TDATA_W-1:0]       tdata,
	output logic                                    tlast
);
	import i2cms_pkg::*;

	res_t [RES_MAX-1:0] bank_q;
	logic [2:0]         cnt_q;
	logic [2:0]         idx_q;
	logic               valid_q;
	logic               at_last;
	res_t               head;

	assign at_last = (idx_q == cnt_q - 3'd1);
	assign free    = !valid_q || (tready && at_last);
	assign head    = bank_q[idx_q];
	assign tvalid  = valid_q;
	assign tlast   = at_last;
	assign tdata   = {5'd0, head.prior_state, head.notice, head.ack_out, head.generate_stop,
		head.generate_start, head.deliver_byte, head.write_data_reg, head.data_out};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= 3'd1;
			idx_q   <= 3'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= count;
			idx_q   <= 3'd0;
		end else if (valid_q && tready) begin
			if (at_last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bank_q <= bank;
		end
	end

endmodule

// File: rtl/i2c_master_transfer_sequencer_unit.sv
// Top level of the I2C master transfer sequencer: input register, transfer
// state, APB register and result stream. Depends on i2cms_pkg, i2cms_step,
// i2cms_outq and assert_macros.svh.
//
// Usage:
//   s_axis carries one command word per beat (start write/read or a bus event
//   from the byte-level controller). m_axis returns the actions and notices
//   that the word causes: one to five words, tlast on the final one.
//   The APB port holds ack_enable at address 0; write it only while idle.
// Timing:
//   An accepted word is registered, then decoded against the transfer state
//   in a single pass and loaded into the result bank once the bank is free;
//   the bank then presents its first result. While m_axis_tready is high, a
//   word giving one result is taken every cycle; a word giving n results
//   holds the output for n words, since the result bank streams one word per
//   cycle and takes the next batch as its last word leaves.
// Reset:
//   arst_n clears the transfer state to ready, all counters to zero, ack on,
//   interrupts off, ack_enable to 1, and empties both stages.
// Stalls:
//   With m_axis_tready low the bank holds its batch; one more input word waits
//   in the input register, then s_axis_tready drops until the bank drains.
module i2c_master_transfer_sequencer_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// command, slave_address, length, repeated_start, data_byte, master_mode,
	// transmitter, tx_empty_too, error_flags; zero pad to 48 bits
	input  logic [i2cms_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// data_out, write_data_reg, deliver_byte, generate_start, generate_stop,
	// ack_out, notice, prior_state; zero pad to 24 bits
	output logic [i2cms_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic                                m_axis_tlast,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready
);
	import i2cms_pkg::*;

	`include "assert_macros.svh"

	item_t              item_s1;
	logic               valid_s1;
	state_t             state_q;
	state_t             state_nxt;
	logic               ack_enable_q;
	res_t [RES_MAX-1:0] bank;
	logic [2:0]         count;
	logic               bank_free;
	logic               process;
	logic               reg_sel;

	// decode the word in s1 once the bank can take its batch
	assign process       = valid_s1 && bank_free;
	assign s_axis_tready = !valid_s1 || process;

	// register file: a single register, word-decoded
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_ACK_ENABLE);
	assign prdata  = reg_sel ? {31'd0, ack_enable_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_enable_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			ack_enable_q <= pwdata[0];
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (process) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			item_s1 <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
		end
	end

	// transfer state advances as each word is decoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{xfer_state: XS_READY, ack: 1'b1, default: '0};
		end else if (process) begin
			state_q <= state_nxt;
		end
	end

	i2cms_step u_step (
		.cur        (state_q),
		.item       (item_s1),
		.ack_enable (ack_enable_q),
		.nxt        (state_nxt),
		.res        (bank),
		.count      (count)
	);

	i2cms_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (process),
		.bank   (bank),
		.count  (count),
		.free   (bank_free),
		.tvalid (m_axis_tvalid),
		.tready (m_axis_tready),
		.tdata  (m_axis_tdata),
		.tlast  (m_axis_tlast)
	);

	// a busy transfer always has its event interrupts on
	`ASSERT_SAME(a_busy_irq, state_q.xfer_state != XS_READY, state_q.ev_on && state_q.buf_on, "busy transfer with event interrupts off")
	// event interrupts are never on without error interrupts
	`ASSERT_SAME(a_err_irq, state_q.ev_on, state_q.err_on, "event interrupts on, error interrupts off")
	// a word waiting for the bank stays put
	`ASSERT_NEXT(a_s1_hold, valid_s1 && !process, valid_s1 && $stable(item_s1), "input register lost a pending word")

endmodule
